/* rtl/lfpd_pkg.sv */
package lfpd_pkg;

    // Field and datapath widths
    localparam int SUM_BITS_DEF = 24;
    localparam int SAMPLE_W     = 10;
    localparam int ERR_W        = 7;
    localparam int DIFF_W       = 8;
    localparam int GAIN_W       = 16;
    localparam int SPEED_W      = 9;
    localparam int DUTY_W       = 8;
    localparam int SPEED_MAX    = 255;

    // The accumulator grows by this many bits over the integral sum width,
    // and the adjustment is the accumulator shifted right by ADJ_SHIFT.
    localparam int ACC_EXTRA    = 19;
    localparam int ADJ_SHIFT    = 8;

    // Configuration port
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIVE_SENSOR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_BIAS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_SPEED  = 3'd6;

    localparam logic [SAMPLE_W-1:0] THRESHOLD_RST = 10'd450;

    // Line error magnitudes, in tenths
    localparam logic signed [ERR_W-1:0] ERR_CENTER = 7'sd0;
    localparam logic signed [ERR_W-1:0] ERR_NEAR   = 7'sd4;
    localparam logic signed [ERR_W-1:0] ERR_MID    = 7'sd19;
    localparam logic signed [ERR_W-1:0] ERR_WIDE   = 7'sd28;
    localparam logic signed [ERR_W-1:0] ERR_EDGE   = 7'sd44;

    typedef struct packed {
        logic [SAMPLE_W-1:0]      threshold;
        logic                     five_sensor_mode;
        logic                     left_bias_mode;
        logic [GAIN_W-1:0]        gain_p;
        logic [GAIN_W-1:0]        gain_i;
        logic [GAIN_W-1:0]        gain_d;
        logic signed [SPEED_W-1:0] base_speed;
    } cfg_t;

    // Load strobes for the pipeline stages after the input register
    typedef struct packed {
        logic load1;
        logic load2;
        logic load3;
        logic load4;
    } pipe_ctl_t;

    typedef struct packed {
        logic                    known;
        logic signed [ERR_W-1:0] err;
    } dec_t;

    // Pattern bits are far left, left, middle, right, far right (MSB first).
    function automatic dec_t decode_pattern(
        input logic [4:0] pat,
        input logic       five,
        input logic       lbias
    );
        dec_t d;
        d.known = 1'b1;
        d.err   = ERR_CENTER;
        if (five)
        begin
            if (lbias)
            begin
                case (pat)
                    5'b00100: d.err = -ERR_NEAR;
                    5'b01100: d.err = -ERR_NEAR;
                    5'b01000: d.err = -ERR_MID;
                    5'b11000: d.err = -ERR_WIDE;
                    5'b10000: d.err = -ERR_EDGE;
                    default:  d.known = 1'b0;
                endcase
            end
            else
            begin
                case (pat)
                    5'b00100: d.err = ERR_CENTER;
                    5'b01100: d.err = -ERR_NEAR;
                    5'b00110: d.err = ERR_NEAR;
                    5'b01000: d.err = -ERR_MID;
                    5'b00010: d.err = ERR_MID;
                    5'b11000: d.err = -ERR_WIDE;
                    5'b00011: d.err = ERR_WIDE;
                    5'b10000: d.err = -ERR_EDGE;
                    5'b00001: d.err = ERR_EDGE;
                    default:  d.known = 1'b0;
                endcase
            end
        end
        else
        begin
            if (lbias)
            begin
                case (pat[3:1])
                    3'b010:  d.err = -ERR_NEAR;
                    3'b110:  d.err = -ERR_NEAR;
                    3'b100:  d.err = -ERR_MID;
                    default: d.known = 1'b0;
                endcase
            end
            else
            begin
                case (pat[3:1])
                    3'b010:  d.err = ERR_CENTER;
                    3'b110:  d.err = -ERR_NEAR;
                    3'b011:  d.err = ERR_NEAR;
                    3'b100:  d.err = -ERR_MID;
                    3'b001:  d.err = ERR_MID;
                    default: d.known = 1'b0;
                endcase
            end
        end
        return d;
    endfunction

endpackage

/* rtl/lfpd_err_stage.sv */
module lfpd_err_stage
    import lfpd_pkg::*;
#(
    parameter int SUM_BITS = SUM_BITS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       load,
    input  logic                       start_req,
    input  logic [SAMPLE_W-1:0]        sample_far_left,
    input  logic [SAMPLE_W-1:0]        sample_left,
    input  logic [SAMPLE_W-1:0]        sample_middle,
    input  logic [SAMPLE_W-1:0]        sample_right,
    input  logic [SAMPLE_W-1:0]        sample_far_right,
    input  cfg_t                       cfg,
    output logic signed [ERR_W-1:0]    err,
    output logic signed [DIFF_W-1:0]   diff,
    output logic signed [SUM_BITS-1:0] sum
);

    logic signed [ERR_W-1:0]    prev_err_reg;
    logic signed [SUM_BITS-1:0] sum_reg;
    logic signed [DIFF_W-1:0]   diff_reg;

    logic signed [ERR_W-1:0]    prev_eff;
    logic signed [SUM_BITS-1:0] sum_eff;
    logic [4:0]                 pattern;
    dec_t                       dec;
    logic signed [ERR_W-1:0]    err_next;
    logic signed [SUM_BITS:0]   sum_wide;
    logic signed [SUM_BITS-1:0] sum_next;
    logic signed [DIFF_W-1:0]   diff_next;

    // A start request clears the history ahead of this tick.
    assign prev_eff = start_req ? '0 : prev_err_reg;
    assign sum_eff  = start_req ? '0 : sum_reg;

    // Threshold each sample; above the threshold reads as black line.
    assign pattern = {sample_far_left  > cfg.threshold,
                      sample_left      > cfg.threshold,
                      sample_middle    > cfg.threshold,
                      sample_right     > cfg.threshold,
                      sample_far_right > cfg.threshold};

    assign dec      = decode_pattern(pattern, cfg.five_sensor_mode, cfg.left_bias_mode);
    assign err_next = dec.known ? dec.err : prev_eff;

    // Saturating integral: on overflow the carry bit gives the direction.
    always_comb
    begin
        sum_wide = $signed({sum_eff[SUM_BITS-1], sum_eff}) + (SUM_BITS+1)'(err_next);
        if (sum_wide[SUM_BITS] != sum_wide[SUM_BITS-1])
        begin
            sum_next = sum_wide[SUM_BITS] ? {1'b1, {(SUM_BITS-1){1'b0}}}
                                          : {1'b0, {(SUM_BITS-1){1'b1}}};
        end
        else
        begin
            sum_next = sum_wide[SUM_BITS-1:0];
        end
    end

    assign diff_next = DIFF_W'(err_next) - DIFF_W'(prev_eff);

    // The history registers also serve as this stage's output for the beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_err_reg <= '0;
            sum_reg      <= '0;
        end
        else if (load)
        begin
            prev_err_reg <= err_next;
            sum_reg      <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            diff_reg <= diff_next;
        end
    end

    assign err  = prev_err_reg;
    assign sum  = sum_reg;
    assign diff = diff_reg;

endmodule

/* rtl/lfpd_pid_math.sv */
module lfpd_pid_math
    import lfpd_pkg::*;
#(
    parameter int SUM_BITS = SUM_BITS_DEF,
    localparam int ADJ_W   = SUM_BITS + ACC_EXTRA - ADJ_SHIFT
)
(
    input  logic                       clk,
    input  pipe_ctl_t                  ctl,
    input  cfg_t                       cfg,
    input  logic signed [ERR_W-1:0]    err,
    input  logic signed [DIFF_W-1:0]   diff,
    input  logic signed [SUM_BITS-1:0] sum,
    output logic signed [ADJ_W-1:0]    adj,
    output logic signed [ERR_W-1:0]    err_out
);

    localparam int PP_W  = GAIN_W + ERR_W + 1;
    localparam int PD_W  = GAIN_W + DIFF_W + 1;
    localparam int PI_W  = GAIN_W + SUM_BITS + 1;
    localparam int ACC_W = SUM_BITS + ACC_EXTRA;

    logic signed [GAIN_W:0]   gp_s;
    logic signed [GAIN_W:0]   gi_s;
    logic signed [GAIN_W:0]   gd_s;
    logic signed [PP_W-1:0]   pp_next;
    logic signed [PI_W-1:0]   pi_next;
    logic signed [PD_W-1:0]   pd_next;
    logic signed [ACC_W-1:0]  acc;

    logic signed [PP_W-1:0]   pp_reg;
    logic signed [PI_W-1:0]   pi_reg;
    logic signed [PD_W-1:0]   pd_reg;
    logic signed [ERR_W-1:0]  err2_reg;
    logic signed [ADJ_W-1:0]  adj_reg;
    logic signed [ERR_W-1:0]  err3_reg;

    // Gains are unsigned; a zero top bit lets them multiply signed terms.
    assign gp_s = {1'b0, cfg.gain_p};
    assign gi_s = {1'b0, cfg.gain_i};
    assign gd_s = {1'b0, cfg.gain_d};

    // Three independent products, registered.
    assign pp_next = gp_s * err;
    assign pi_next = gi_s * sum;
    assign pd_next = gd_s * diff;

    always_ff @(posedge clk)
    begin
        if (ctl.load2)
        begin
            pp_reg   <= pp_next;
            pi_reg   <= pi_next;
            pd_reg   <= pd_next;
            err2_reg <= err;
        end
    end

    // Sum of the terms; dropping the low bits is a floor division by 256.
    assign acc = ACC_W'(pp_reg) + ACC_W'(pi_reg) + ACC_W'(pd_reg);

    always_ff @(posedge clk)
    begin
        if (ctl.load3)
        begin
            adj_reg  <= acc[ACC_W-1:ADJ_SHIFT];
            err3_reg <= err2_reg;
        end
    end

    assign adj     = adj_reg;
    assign err_out = err3_reg;

endmodule

/* rtl/lfpd_motor_out.sv */
module lfpd_motor_out
    import lfpd_pkg::*;
#(
    parameter int ADJ_W = SUM_BITS_DEF + ACC_EXTRA - ADJ_SHIFT
)
(
    input  logic                        clk,
    input  logic                        load,
    input  logic signed [SPEED_W-1:0]   base_speed,
    input  logic signed [ADJ_W-1:0]     adj,
    input  logic signed [ERR_W-1:0]     err_in,
    output logic                        left_forward,
    output logic [DUTY_W-1:0]           left_duty,
    output logic                        right_forward,
    output logic [DUTY_W-1:0]           right_duty,
    output logic signed [ERR_W-1:0]     line_error
);

    localparam int SPD_W = ADJ_W + 2;
    localparam logic signed [SPD_W-1:0] SPD_HI = SPD_W'(SPEED_MAX);
    localparam logic signed [SPD_W-1:0] SPD_LO = -SPD_HI;

    logic signed [SPD_W-1:0]   speed_l;
    logic signed [SPD_W-1:0]   speed_r;
    logic signed [SPEED_W-1:0] clamp_l;
    logic signed [SPEED_W-1:0] clamp_r;
    logic signed [SPEED_W-1:0] neg_l;
    logic signed [SPEED_W-1:0] neg_r;

    logic                      left_forward_reg;
    logic [DUTY_W-1:0]         left_duty_reg;
    logic                      right_forward_reg;
    logic [DUTY_W-1:0]         right_duty_reg;
    logic signed [ERR_W-1:0]   line_error_reg;

    function automatic logic signed [SPEED_W-1:0] clamp_speed(
        input logic signed [SPD_W-1:0] v
    );
        logic signed [SPEED_W-1:0] r;
        if (v > SPD_HI)
        begin
            r = SPEED_W'(SPD_HI);
        end
        else if (v < SPD_LO)
        begin
            r = SPEED_W'(SPD_LO);
        end
        else
        begin
            r = SPEED_W'(v);
        end
        return r;
    endfunction

    // Steering: the left motor gets base plus adjustment, the right minus.
    assign speed_l = SPD_W'(base_speed) + SPD_W'(adj);
    assign speed_r = SPD_W'(base_speed) - SPD_W'(adj);
    assign clamp_l = clamp_speed(speed_l);
    assign clamp_r = clamp_speed(speed_r);
    assign neg_l   = -clamp_l;
    assign neg_r   = -clamp_r;

    // Result register: direction bit and duty per motor, and the line error.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            left_forward_reg  <= ~clamp_l[SPEED_W-1];
            left_duty_reg     <= clamp_l[SPEED_W-1] ? neg_l[DUTY_W-1:0] : clamp_l[DUTY_W-1:0];
            right_forward_reg <= ~clamp_r[SPEED_W-1];
            right_duty_reg    <= clamp_r[SPEED_W-1] ? neg_r[DUTY_W-1:0] : clamp_r[DUTY_W-1:0];
            line_error_reg    <= err_in;
        end
    end

    assign left_forward  = left_forward_reg;
    assign left_duty     = left_duty_reg;
    assign right_forward = right_forward_reg;
    assign right_duty    = right_duty_reg;
    assign line_error    = line_error_reg;

endmodule

/* rtl/line_follow_pid_drive.sv */
// Line follower PID drive: one control tick per input beat.
// Input stream (s_*): each beat carries five reflectance samples in tdata
// and the start request in tuser. Output stream (m_*): one beat per input
// beat with the direction and duty of both motors and the line error used.
// Configuration is written through cfg_we / cfg_index / cfg_data at any
// edge with cfg_we high; the user must write only while no tick is in
// flight, which the block does not enforce. A beat passes the input
// register, error decode and history, products, accumulate and result
// register; the five-stage pipeline takes one beat per cycle if not stalled.
// The error history and integral update as a beat leaves the input
// register, so consecutive ticks follow each other without a gap.
// Reset clears the history, all stage valid bits and loads the register
// defaults (threshold 450, five-sensor mode, gains and base speed zero).
// When the receiver stalls, the result register holds and each earlier
// stage keeps accepting until it is full; s_tready falls only when every
// stage holds a beat.
module line_follow_pid_drive
    import lfpd_pkg::*;
#(
    parameter int SUM_BITS = SUM_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // sample_far_left[9:0], sample_left[19:10], sample_middle[29:20],
    // sample_right[39:30], sample_far_right[49:40], zero fill[55:50]
    input  logic [55:0]           s_tdata,
    // start_req[0]
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // left_forward[0], left_duty[8:1], right_forward[9], right_duty[17:10],
    // line_error[24:18], zero fill[31:25]
    output logic [31:0]           m_tdata,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int ADJ_W = SUM_BITS + ACC_EXTRA - ADJ_SHIFT;

    cfg_t                       cfg_reg;
    logic                       v0_reg, v1_reg, v2_reg, v3_reg, v4_reg;
    logic                       v0_next, v1_next, v2_next, v3_next, v4_next;
    logic                       ld0;
    pipe_ctl_t                  ctl;

    logic                       start_reg;
    logic [SAMPLE_W-1:0]        far_left_reg, left_reg, middle_reg, right_reg, far_right_reg;

    logic signed [ERR_W-1:0]    err1;
    logic signed [DIFF_W-1:0]   diff1;
    logic signed [SUM_BITS-1:0] sum1;
    logic signed [ADJ_W-1:0]    adj3;
    logic signed [ERR_W-1:0]    err3;

    logic                       left_forward, right_forward;
    logic [DUTY_W-1:0]          left_duty, right_duty;
    logic signed [ERR_W-1:0]    line_error;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold        <= THRESHOLD_RST;
            cfg_reg.five_sensor_mode <= 1'b1;
            cfg_reg.left_bias_mode   <= 1'b0;
            cfg_reg.gain_p           <= '0;
            cfg_reg.gain_i           <= '0;
            cfg_reg.gain_d           <= '0;
            cfg_reg.base_speed       <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_THRESHOLD:   cfg_reg.threshold        <= cfg_data[SAMPLE_W-1:0];
                CFG_FIVE_SENSOR: cfg_reg.five_sensor_mode <= cfg_data[0];
                CFG_LEFT_BIAS:   cfg_reg.left_bias_mode   <= cfg_data[0];
                CFG_GAIN_P:      cfg_reg.gain_p           <= cfg_data[GAIN_W-1:0];
                CFG_GAIN_I:      cfg_reg.gain_i           <= cfg_data[GAIN_W-1:0];
                CFG_GAIN_D:      cfg_reg.gain_d           <= cfg_data[GAIN_W-1:0];
                CFG_BASE_SPEED:  cfg_reg.base_speed       <= $signed(cfg_data[SPEED_W-1:0]);
                default:         ;
            endcase
        end
    end

    // Stage handshake: a stage loads when it is empty or its beat moves on.
    always_comb
    begin
        ctl.load4 = v3_reg && (!v4_reg || m_tready);
        ctl.load3 = v2_reg && (!v3_reg || ctl.load4);
        ctl.load2 = v1_reg && (!v2_reg || ctl.load3);
        ctl.load1 = v0_reg && (!v1_reg || ctl.load2);
        s_tready  = !v0_reg || ctl.load1;
        ld0       = s_tvalid && s_tready;
        v0_next   = ld0       || (v0_reg && !ctl.load1);
        v1_next   = ctl.load1 || (v1_reg && !ctl.load2);
        v2_next   = ctl.load2 || (v2_reg && !ctl.load3);
        v3_next   = ctl.load3 || (v3_reg && !ctl.load4);
        v4_next   = ctl.load4 || (v4_reg && !m_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= v0_next;
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    // Input register
    always_ff @(posedge clk)
    begin
        if (ld0)
        begin
            start_reg     <= s_tuser;
            far_left_reg  <= s_tdata[9:0];
            left_reg      <= s_tdata[19:10];
            middle_reg    <= s_tdata[29:20];
            right_reg     <= s_tdata[39:30];
            far_right_reg <= s_tdata[49:40];
        end
    end

    lfpd_err_stage #(
        .SUM_BITS (SUM_BITS)
    ) u_err (
        .clk              (clk),
        .rst_n            (rst_n),
        .load             (ctl.load1),
        .start_req        (start_reg),
        .sample_far_left  (far_left_reg),
        .sample_left      (left_reg),
        .sample_middle    (middle_reg),
        .sample_right     (right_reg),
        .sample_far_right (far_right_reg),
        .cfg              (cfg_reg),
        .err              (err1),
        .diff             (diff1),
        .sum              (sum1)
    );

    lfpd_pid_math #(
        .SUM_BITS (SUM_BITS)
    ) u_pid (
        .clk     (clk),
        .ctl     (ctl),
        .cfg     (cfg_reg),
        .err     (err1),
        .diff    (diff1),
        .sum     (sum1),
        .adj     (adj3),
        .err_out (err3)
    );

    lfpd_motor_out #(
        .ADJ_W (ADJ_W)
    ) u_motor (
        .clk           (clk),
        .load          (ctl.load4),
        .base_speed    (cfg_reg.base_speed),
        .adj           (adj3),
        .err_in        (err3),
        .left_forward  (left_forward),
        .left_duty     (left_duty),
        .right_forward (right_forward),
        .right_duty    (right_duty),
        .line_error    (line_error)
    );

    assign m_tvalid = v4_reg;
    assign m_tdata  = {7'b0, line_error, right_duty, right_forward, left_duty, left_forward};

endmodule

/* rtl/lfpd_checker.sv */
module lfpd_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [55:0] s_tdata,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // A stalled input beat stays put until the block takes it.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && !s_tready |=> s_tvalid && $stable({s_tuser, s_tdata}))
        else $error("input beat changed while stalled");

    // A stalled result beat stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output beat changed while stalled");

    // With the result register free to move, the pipeline takes a new beat.
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid || m_tready |-> s_tready)
        else $error("input stalled while output side is free");

    // The line error stays within the table range.
    a_error_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata[24:18]) >= -44) && ($signed(m_tdata[24:18]) <= 44))
        else $error("line error out of range");

    // A reverse direction always comes with a nonzero duty, on either motor.
    a_reverse_duty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[0] || m_tdata[8:1] != 8'd0)
                  && (m_tdata[9] || m_tdata[17:10] != 8'd0))
        else $error("reverse direction with zero duty");

endmodule

bind line_follow_pid_drive lfpd_checker u_lfpd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
);
